### sv/lte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lte_pkg;

  // Fixed field widths.
  localparam int LatBits      = 24;
  localparam int MultBits     = 8;
  localparam int TimeoutBits  = 32;

  // Calibration batch size and the largest batch the index field can address.
  localparam int CalSamples    = 20;
  localparam int CalSamplesMax = 64;
  localparam int IdxMaxBits    = $clog2(CalSamplesMax);

  // Depth of the queue between the classifier and the execution back end.
  localparam int QueueDepth = 2;

  localparam logic [MultBits-1:0] MultReset = MultBits'(5);

  localparam logic CmdRestart = 1'b1;

  // Division by the tracking gain as a multiply by a rounded-up reciprocal.
  // Three guard bits beyond the dividend width keep the quotient exact.
  localparam int GainDiv    = 5;
  localparam int RecipShift = LatBits + 3;
  localparam int RecipBits  = LatBits + 1;
  localparam logic [RecipBits-1:0] RecipGain =
    RecipBits'(((64'd1 << RecipShift) + 64'(GainDiv) - 64'd1) / 64'(GainDiv));

  typedef enum logic [1:0] {
    KIND_RESTART,
    KIND_COLLECT,
    KIND_COLLECT_LAST,
    KIND_TRACK
  } item_kind_e;

  typedef struct packed {
    item_kind_e                 kind;
    logic [IdxMaxBits-1:0]      idx;
    logic [LatBits-1:0]         latency;
  } work_item_t;

  localparam int WorkItemBits = $bits(work_item_t);

endpackage

`default_nettype wire

### sv/lte_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lte_front #(
  parameter int CAL_SAMPLES = lte_pkg::CalSamples
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        command_i,
  input  logic [lte_pkg::LatBits-1:0] latency_us_i,
  output logic                        full_o,
  output logic                        q_push_o,
  output lte_pkg::work_item_t         q_item_o,
  input  logic                        q_full_i
);
  import lte_pkg::*;

  localparam int IdxBits = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(CAL_SAMPLES - 1);

  logic [IdxBits-1:0] cnt_q, cnt_d;
  logic               cal_q, cal_d;
  logic               accept;
  work_item_t         item;

  assign full_o = q_full_i;
  assign accept = push_i & ~q_full_i;

  // The front end tracks the calibration phase itself, so every item leaves
  // here already tagged with what the back end must do with it.
  always_comb begin
    cnt_d        = cnt_q;
    cal_d        = cal_q;
    item.idx     = IdxMaxBits'(cnt_q);
    item.latency = latency_us_i;
    if (command_i == CmdRestart) begin
      item.kind = KIND_RESTART;
      cnt_d     = '0;
      cal_d     = 1'b0;
    end else if (cal_q) begin
      item.kind = KIND_TRACK;
    end else if (cnt_q == LastIdx) begin
      item.kind = KIND_COLLECT_LAST;
      cnt_d     = '0;
      cal_d     = 1'b1;
    end else begin
      item.kind = KIND_COLLECT;
      cnt_d     = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cal_q <= 1'b0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      cal_q <= cal_d;
    end
  end

  assign q_push_o = accept;
  assign q_item_o = item;

endmodule

`default_nettype wire

### sv/lte_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module lte_fifo #(
  parameter int WIDTH = lte_pkg::WorkItemBits,
  parameter int DEPTH = lte_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);

  logic [WIDTH-1:0]   entry_q [DEPTH];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntBits'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### sv/lte_div.sv
`timescale 1ns / 1ps
`default_nettype none

module lte_div #(
  parameter int WIDTH   = lte_pkg::LatBits,
  parameter int DIVISOR = lte_pkg::CalSamples
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o
);

  // Division by a constant as a multiply by the rounded-up reciprocal. With the
  // shift at the dividend width plus clog2 of the divisor the quotient is exact
  // for every dividend. The product is registered, so done follows start through the
  // multiply flag and the done register, and the quotient holds until the next start.
  localparam int ShiftBits = WIDTH + $clog2(DIVISOR);
  localparam int RecBits   = WIDTH + 1;
  localparam int ProdBits  = WIDTH + RecBits;
  localparam logic [RecBits-1:0] Recip =
    RecBits'(((64'd1 << ShiftBits) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [WIDTH-1:0]    dvd_q;
  logic [ProdBits-1:0] prod_q;
  logic                mul_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      done_q <= mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (mul_q) begin
      prod_q <= ProdBits'(dvd_q) * ProdBits'(Recip);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = WIDTH'(prod_q >> ShiftBits);

endmodule

`default_nettype wire

### sv/lte_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lte_back #(
  parameter int CAL_SAMPLES = lte_pkg::CalSamples
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  lte_pkg::work_item_t             q_item_i,
  output logic                            q_pop_o,
  input  logic [lte_pkg::MultBits-1:0]    mult_i,
  input  logic                            pop_i,
  output logic                            empty_o,
  output logic [lte_pkg::TimeoutBits-1:0] timeout_us_o,
  output logic [lte_pkg::LatBits-1:0]     average_us_o,
  output logic [lte_pkg::LatBits-1:0]     deviation_us_o,
  output logic                            calibrated_o
);
  import lte_pkg::*;

  localparam int IdxBits   = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
  localparam int SumBits   = LatBits + $clog2(CAL_SAMPLES);
  localparam int ProdBits  = LatBits + MultBits;
  localparam int RecipProd = LatBits + RecipBits;
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(CAL_SAMPLES - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRK_ERR,
    S_TRK_DIFF,
    S_TRK_MUL,
    S_TRK_UPD,
    S_SCALE,
    S_OUT,
    S_AVG_START,
    S_AVG_WAIT,
    S_WALK,
    S_WALK_END,
    S_DEV_START,
    S_DEV_WAIT
  } state_e;

  state_e state_q;

  logic                   ready_q;
  logic [LatBits-1:0]     avg_q, dev_q;
  logic [SumBits-1:0]     sum_q, devsum_q;
  logic [IdxBits-1:0]     walk_q;
  logic                   rd_v_q;
  logic [LatBits-1:0]     rd_q;
  logic [LatBits-1:0]     store_q [CAL_SAMPLES];

  logic [LatBits-1:0]     lat_q;
  logic                   err_neg_q, diff_neg_q;
  logic [LatBits-1:0]     err_mag_q, diff_mag_q;
  logic [RecipProd-1:0]   rec_avg_q, rec_dev_q;
  logic [ProdBits-1:0]    prod_q;

  logic                   oval_q;
  logic [TimeoutBits-1:0] tmo_q;
  logic [LatBits-1:0]     out_avg_q, out_dev_q;
  logic                   out_cal_q;

  logic                   div_start, div_done;
  logic [SumBits-1:0]     div_dividend, div_quot;

  logic [LatBits-1:0]     step_avg, step_dev, avg_upd, dev_upd, walk_abs;
  logic [TimeoutBits:0]   tsum;
  logic [TimeoutBits-1:0] tmo;

  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;

  assign div_start    = (state_q == S_AVG_START) || (state_q == S_DEV_START);
  assign div_dividend = (state_q == S_AVG_START) ? sum_q : devsum_q;

  lte_div #(
    .WIDTH   (SumBits),
    .DIVISOR (CAL_SAMPLES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Tracking update: the two divisions by the gain work on magnitudes, so
  // applying the sign afterwards gives truncation toward zero.
  assign step_avg = LatBits'(rec_avg_q >> RecipShift);
  assign step_dev = LatBits'(rec_dev_q >> RecipShift);
  assign avg_upd  = err_neg_q ? avg_q - step_avg : avg_q + step_avg;
  assign dev_upd  = diff_neg_q ? dev_q - step_dev : dev_q + step_dev;

  assign walk_abs = (rd_q >= avg_q) ? rd_q - avg_q : avg_q - rd_q;

  assign tsum = (TimeoutBits + 1)'(avg_q) + (TimeoutBits + 1)'(prod_q);
  assign tmo  = tsum[TimeoutBits] ? '1 : tsum[TimeoutBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ready_q   <= 1'b0;
      avg_q     <= '0;
      dev_q     <= '0;
      sum_q     <= '0;
      walk_q    <= '0;
      rd_v_q    <= 1'b0;
      oval_q    <= 1'b0;
      tmo_q     <= '0;
      out_avg_q <= '0;
      out_dev_q <= '0;
      out_cal_q <= 1'b0;
    end else begin
      rd_v_q <= 1'b0;
      if (pop_i && oval_q && (state_q != S_OUT)) begin
        oval_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            unique case (q_item_i.kind)
              KIND_RESTART: begin
                ready_q <= 1'b0;
                avg_q   <= '0;
                dev_q   <= '0;
                sum_q   <= '0;
                state_q <= S_SCALE;
              end
              KIND_COLLECT: begin
                sum_q   <= sum_q + SumBits'(q_item_i.latency);
                state_q <= S_SCALE;
              end
              KIND_COLLECT_LAST: begin
                sum_q   <= sum_q + SumBits'(q_item_i.latency);
                state_q <= S_AVG_START;
              end
              KIND_TRACK: begin
                state_q <= S_TRK_ERR;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_TRK_ERR:  state_q <= S_TRK_DIFF;
        S_TRK_DIFF: state_q <= S_TRK_MUL;
        S_TRK_MUL:  state_q <= S_TRK_UPD;
        S_TRK_UPD: begin
          avg_q   <= avg_upd;
          dev_q   <= dev_upd;
          state_q <= S_SCALE;
        end
        S_SCALE: state_q <= S_OUT;
        S_OUT: begin
          if (!oval_q || pop_i) begin
            oval_q    <= 1'b1;
            tmo_q     <= ready_q ? tmo : '0;
            out_avg_q <= ready_q ? avg_q : '0;
            out_dev_q <= ready_q ? dev_q : '0;
            out_cal_q <= ready_q;
            state_q   <= S_IDLE;
          end
        end
        S_AVG_START: state_q <= S_AVG_WAIT;
        S_AVG_WAIT: begin
          if (div_done) begin
            avg_q   <= div_quot[LatBits-1:0];
            walk_q  <= '0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          rd_v_q <= 1'b1;
          if (walk_q == LastIdx) begin
            state_q <= S_WALK_END;
          end else begin
            walk_q <= walk_q + 1'b1;
          end
        end
        S_WALK_END:  state_q <= S_DEV_START;
        S_DEV_START: state_q <= S_DEV_WAIT;
        S_DEV_WAIT: begin
          if (div_done) begin
            dev_q   <= div_quot[LatBits-1:0];
            ready_q <= 1'b1;
            state_q <= S_SCALE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Sample store: written while collecting, read once per entry in the walk.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && (q_item_i.kind inside {KIND_COLLECT, KIND_COLLECT_LAST})) begin
      store_q[q_item_i.idx[IdxBits-1:0]] <= q_item_i.latency;
    end
    rd_q <= store_q[walk_q];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      lat_q <= q_item_i.latency;
    end
    if (state_q == S_TRK_ERR) begin
      err_neg_q <= (lat_q < avg_q);
      err_mag_q <= (lat_q < avg_q) ? avg_q - lat_q : lat_q - avg_q;
    end
    if (state_q == S_TRK_DIFF) begin
      diff_neg_q <= (err_mag_q < dev_q);
      diff_mag_q <= (err_mag_q < dev_q) ? dev_q - err_mag_q : err_mag_q - dev_q;
    end
    if (state_q == S_TRK_MUL) begin
      rec_avg_q <= RecipProd'(err_mag_q) * RecipProd'(RecipGain);
      rec_dev_q <= RecipProd'(diff_mag_q) * RecipProd'(RecipGain);
    end
    if (state_q == S_SCALE) begin
      prod_q <= ProdBits'(dev_q) * ProdBits'(mult_i);
    end
    if (state_q == S_AVG_WAIT) begin
      devsum_q <= '0;
    end else if (rd_v_q) begin
      devsum_q <= devsum_q + SumBits'(walk_abs);
    end
  end

  assign empty_o        = ~oval_q;
  assign timeout_us_o   = tmo_q;
  assign average_us_o   = out_avg_q;
  assign deviation_us_o = out_dev_q;
  assign calibrated_o   = out_cal_q;

`ifndef ASSERT_OFF
  a_track_needs_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.kind == KIND_TRACK) |-> ready_q)
    else $error("tracking transaction taken while uncalibrated");

  a_batch_needs_uncal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.kind == KIND_COLLECT_LAST) |-> !ready_q)
    else $error("batch completion taken while already calibrated");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_AVG_WAIT || state_q == S_DEV_WAIT))
    else $error("divider finished outside a wait state");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && oval_q && !pop_i) |=> (state_q == S_OUT && oval_q))
    else $error("pending result overwritten or dropped");
`endif

endmodule

`default_nettype wire

### sv/latency_timeout_estimator.sv
// A tracked sample passes the back-end states error, difference, multiply and update, then
// scale and output; a restart or a collected sample goes straight to scale and output; the
// sample that completes the batch first runs the store walk over N entries and two
// reciprocal-multiply divisions. The back end pops a new transaction only after the last
// one has left the output state, which waits while an unpopped result is held.
// Asynchronous active-low reset clears calibration, estimates and sets the multiplier to 5.
`timescale 1ns / 1ps
`default_nettype none

module latency_timeout_estimator #(
  parameter int CAL_SAMPLES = lte_pkg::CalSamples
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // Input queue side.
  input  logic                            push,
  output logic                            full,
  input  logic                            command_i,
  input  logic [lte_pkg::LatBits-1:0]     latency_us_i,

  // Configuration write channel for the deviation multiplier.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lte_pkg::MultBits-1:0]    cfg_data_i,

  // Result queue side.
  output logic                            empty,
  input  logic                            pop,
  output logic [lte_pkg::TimeoutBits-1:0] timeout_us_o,
  output logic [lte_pkg::LatBits-1:0]     average_us_o,
  output logic [lte_pkg::LatBits-1:0]     deviation_us_o,
  output logic                            calibrated_o
);
  import lte_pkg::*;

  // The front end classifies each incoming transaction against its own view
  // of the calibration phase (restart, collect, batch completion, tracking)
  // and pushes it into a short queue. The back end pops one transaction at a
  // time, runs the matching sequence and parks the result in an output
  // register, so new transactions keep landing in the queue while a result
  // waits to be taken. The sample store is not cleared; every entry is
  // written by the current batch before the walk reads it.

  logic [MultBits-1:0]     mult_q;
  logic                    fq_push, fq_full, fq_pop, fq_empty;
  work_item_t              fe_item, be_item;
  logic [WorkItemBits-1:0] fq_rdata;

  // The multiplier register accepts a write in every cycle. Software must only
  // change it while no transaction is in flight; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MultReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mult_q <= cfg_data_i;
    end
  end

  lte_front #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .command_i    (command_i),
    .latency_us_i (latency_us_i),
    .full_o       (full),
    .q_push_o     (fq_push),
    .q_item_o     (fe_item),
    .q_full_i     (fq_full)
  );

  lte_fifo #(
    .WIDTH (WorkItemBits),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fe_item),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .data_o  (fq_rdata),
    .empty_o (fq_empty)
  );

  assign be_item = work_item_t'(fq_rdata);

  // The back end owns the estimates, the sample store, the batch divider
  // and the output register.
  lte_back #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (fq_empty),
    .q_item_i       (be_item),
    .q_pop_o        (fq_pop),
    .mult_i         (mult_q),
    .pop_i          (pop),
    .empty_o        (empty),
    .timeout_us_o   (timeout_us_o),
    .average_us_o   (average_us_o),
    .deviation_us_o (deviation_us_o),
    .calibrated_o   (calibrated_o)
  );

endmodule

`default_nettype wire

### sim/latency_timeout_estimator_checker.sv
`timescale 1ns / 1ps

module latency_timeout_estimator_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            full_i,
  input  logic                            command_i,
  input  logic [lte_pkg::LatBits-1:0]     latency_us_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lte_pkg::MultBits-1:0]    cfg_data_i,
  input  logic                            empty_i,
  input  logic                            pop_i,
  input  logic [lte_pkg::TimeoutBits-1:0] timeout_us_i,
  input  logic [lte_pkg::LatBits-1:0]     average_us_i,
  input  logic [lte_pkg::LatBits-1:0]     deviation_us_i,
  input  logic                            calibrated_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int PrintLimit = 40;

  typedef struct packed {
    logic [lte_pkg::TimeoutBits-1:0] timeout;
    logic [lte_pkg::LatBits-1:0]     average;
    logic [lte_pkg::LatBits-1:0]     deviation;
    logic                            calibrated;
  } estimate_t;

  // Shadow copy of the estimator state.
  logic [lte_pkg::MultBits-1:0] multiplier;
  logic [lte_pkg::LatBits-1:0]  batch [lte_pkg::CalSamples];
  int                           batch_fill;
  longint                       batch_sum;
  logic [lte_pkg::LatBits-1:0]  avg_est;
  logic [lte_pkg::LatBits-1:0]  dev_est;
  logic                         is_calibrated;

  estimate_t estimates_due[$];
  int        failures = 0;

  task automatic clear_estimates();
    batch_fill    = 0;
    batch_sum     = 0;
    avg_est       = '0;
    dev_est       = '0;
    is_calibrated = 1'b0;
  endtask

  // Applies one accepted transaction to the shadow state and queues the result it causes.
  task automatic absorb_item(input logic cmd, input logic [lte_pkg::LatBits-1:0] lat);
    longint    err;
    longint    mag;
    longint    level;
    longint    spread_sum;
    int        i;
    estimate_t due;
    if (cmd == lte_pkg::CmdRestart) begin
      clear_estimates();
    end else if (!is_calibrated) begin
      if (batch_fill < lte_pkg::CalSamples) begin
        batch[batch_fill] = lat;
        batch_fill++;
        batch_sum += longint'(lat);
      end
      if (batch_fill >= lte_pkg::CalSamples) begin
        level      = batch_sum / lte_pkg::CalSamples;
        spread_sum = 0;
        for (i = 0; i < lte_pkg::CalSamples; i++) begin
          mag = longint'(batch[i]) - level;
          spread_sum += (mag < 0) ? -mag : mag;
        end
        avg_est       = lte_pkg::LatBits'(level);
        dev_est       = lte_pkg::LatBits'(spread_sum / lte_pkg::CalSamples);
        is_calibrated = 1'b1;
      end
    end else begin
      // Signed divisions truncate toward zero, as the gain update requires.
      err     = longint'(lat) - longint'(avg_est);
      mag     = (err < 0) ? -err : err;
      avg_est = lte_pkg::LatBits'(longint'(avg_est) + err / lte_pkg::GainDiv);
      dev_est = lte_pkg::LatBits'(longint'(dev_est)
                + (mag - longint'(dev_est)) / lte_pkg::GainDiv);
    end

    due = '0;
    if (is_calibrated) begin
      level = longint'(avg_est) + longint'(dev_est) * longint'(multiplier);
      if (level > 64'hFFFF_FFFF) level = 64'hFFFF_FFFF;
      due.timeout    = lte_pkg::TimeoutBits'(level);
      due.average    = avg_est;
      due.deviation  = dev_est;
      due.calibrated = 1'b1;
    end
    estimates_due.push_back(due);
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (failures < PrintLimit)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    end
  endtask

  task automatic compare_result();
    estimate_t due;
    if (estimates_due.size() == 0) begin
      if (failures < PrintLimit)
        $display("%0t: result with no transaction outstanding, expected none, actual %0d",
                 $time, timeout_us_i);
      failures++;
    end else begin
      due = estimates_due.pop_front();
      check_field("timeout_us", due.timeout, timeout_us_i);
      check_field("average_us", due.average, average_us_i);
      check_field("deviation_us", due.deviation, deviation_us_i);
      check_field("calibrated", due.calibrated, calibrated_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_estimates();
      multiplier = lte_pkg::MultReset;
      estimates_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) multiplier = cfg_data_i;
      if (push_i && !full_i) absorb_item(command_i, latency_us_i);
      if (pop_i && !empty_i) compare_result();
    end
    pending_o    <= estimates_due.size();
    fail_count_o <= failures;
  end

endmodule

### sim/latency_timeout_estimator_tb.sv
`timescale 1ns / 1ps

module latency_timeout_estimator_tb;

  // A latency sample is the complement of the restart command.
  localparam logic CmdSample = ~lte_pkg::CmdRestart;

  // Each side is idle with a chance of roughly 17 percent, except in the steady phase.
  localparam int IdlePercent = 17;
  localparam int RandomPerPhase = 150;
  localparam int PhaseCount = 5;

  // The slowest item is the one that completes the calibration batch, with its store
  // walk and two divisions. The drain wait covers that with margin.
  localparam int DrainCycles = 150;

  // About 800 transactions; even if every one were a batch completion waiting out
  // the longest pop stall, this limit is several times what a correct run needs.
  localparam int CycleLimit = 400000;

  logic clk;
  logic rst_n;

  logic                            push;
  logic                            full;
  logic                            command;
  logic [lte_pkg::LatBits-1:0]     latency_us;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [lte_pkg::MultBits-1:0]    cfg_data;
  logic                            empty;
  logic                            pop;
  logic [lte_pkg::TimeoutBits-1:0] timeout_us;
  logic [lte_pkg::LatBits-1:0]     average_us;
  logic [lte_pkg::LatBits-1:0]     deviation_us;
  logic                            calibrated;

  int   fail_count;
  int   pending;
  int   cycles;
  logic steady;

  latency_timeout_estimator DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .command_i      (command),
    .latency_us_i   (latency_us),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .empty          (empty),
    .pop            (pop),
    .timeout_us_o   (timeout_us),
    .average_us_o   (average_us),
    .deviation_us_o (deviation_us),
    .calibrated_o   (calibrated)
  );

  latency_timeout_estimator_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push_i         (push),
    .full_i         (full),
    .command_i      (command),
    .latency_us_i   (latency_us),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .empty_i        (empty),
    .pop_i          (pop),
    .timeout_us_i   (timeout_us),
    .average_us_i   (average_us),
    .deviation_us_i (deviation_us),
    .calibrated_i   (calibrated),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side pops at random, changing only at the falling edge so that the
  // block and the checker both see a settled value at the rising edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Offers one transaction and holds it until the block takes it. Push is left high
  // afterwards; the next call either replaces the item or lowers push for a gap, so
  // push gets only one assignment per falling edge.
  task automatic send_item(input logic cmd, input logic [lte_pkg::LatBits-1:0] lat);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    command    <= cmd;
    latency_us <= lat;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Lowers push and waits until every result has been popped, so the block is idle.
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // The multiplier is only written while the block holds no work.
  task automatic write_multiplier(input logic [lte_pkg::MultBits-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [lte_pkg::MultBits-1:0] mult;
    int unsigned                  base;
    int unsigned                  spread;
    int unsigned                  near;
    int unsigned                  roll;

    rst_n      = 1'b0;
    push       = 1'b0;
    command    = CmdSample;
    latency_us = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    pop        = 1'b0;
    steady     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, with the multiplier at its reset value. A restart while
    // uncalibrated must answer all zeros.
    send_item(lte_pkg::CmdRestart, 24'hFFFFFF);

    // One full calibration batch. The field extremes and both alternating bit
    // patterns go in first; the rest sit near 1000 us. The last sample must
    // already answer with the calibrated estimate.
    send_item(CmdSample, 24'h000000);
    send_item(CmdSample, 24'hFFFFFF);
    send_item(CmdSample, 24'hAAAAAA);
    send_item(CmdSample, 24'h555555);
    repeat (lte_pkg::CalSamples - 4) send_item(CmdSample, 24'($urandom_range(900, 1100)));

    // Tracking with a sample at each field extreme and one at 1000 us.
    send_item(CmdSample, 24'hFFFFFF);
    send_item(CmdSample, 24'h000000);
    send_item(CmdSample, 24'd1000);

    // Restart from the calibrated state; the latency field must be ignored.
    send_item(lte_pkg::CmdRestart, 24'h123456);
    drain_results();

    // Random phases, each with its own multiplier: both extremes, one, and random
    // values. Most transactions are samples around a per-phase level so that the
    // tracker settles; restarts are rare so calibration completes often.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       mult = '0;
        1:       mult = '1;
        2:       mult = 8'd1;
        default: mult = 8'($urandom_range(255));
      endcase
      write_multiplier(mult);

      // Phase 2 runs with no idle cycles on either side.
      steady = (phase == 2);
      base   = $urandom_range(16000000);
      spread = (phase % 2 == 0) ? $urandom_range(64) : $urandom_range(1000000);

      repeat (RandomPerPhase) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          send_item(lte_pkg::CmdRestart, 24'($urandom()));
        end else if (roll < 10) begin
          send_item(CmdSample, $urandom_range(1) ? 24'hFFFFFF : 24'h000000);
        end else if (roll < 30) begin
          send_item(CmdSample, 24'($urandom()));
        end else begin
          near = base + $urandom_range(spread);
          send_item(CmdSample, (near > 32'hFFFFFF) ? 24'hFFFFFF : 24'(near));
        end
      end
      drain_results();
      steady = 1'b0;
    end

    // Let any stray result surface before the verdict.
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
